// ===== hw/rtl/tcce_pkg.sv =====
package tcce_pkg;

   // Default geometry of the cell store
   localparam int MAX_COLUMNS_DEF = 128;
   localparam int MAX_LINES_DEF   = 64;

   // Fixed field widths
   localparam int ROW_W       = 13;
   localparam int CELL_W      = 16;
   localparam int CODE_W      = 8;
   localparam int COLOR_W     = 8;
   localparam int CFG_COLS_W  = 8;
   localparam int CFG_LINES_W = 7;
   localparam int CFG_ROWS_W  = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int READ_LINE_W = 6;
   localparam int READ_COL_W  = 7;
   localparam int OUT_COL_W   = 7;
   localparam int OUT_LINE_W  = 6;

   // Request command codes
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Character codes
   localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CODE_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'h10;
   localparam logic [CODE_W-1:0] CH_BLANK     = 8'h20;

   // Display row saturation bounds
   localparam logic signed [ROW_W-1:0] ROW_MIN = -13'sd4096;
   localparam logic signed [ROW_W-1:0] ROW_MAX = 13'sd4095;

   // Register reset values
   localparam logic [COLOR_W-1:0]     RST_TEXT_COLOR  = 8'd15;
   localparam logic [CFG_COLS_W-1:0]  RST_COLUMNS     = 8'd80;
   localparam logic [CFG_LINES_W-1:0] RST_LINES       = 7'd64;
   localparam logic [CFG_ROWS_W-1:0]  RST_SCREEN_ROWS = 7'd25;

   localparam logic [CELL_W-1:0] CELL_RESET = {RST_TEXT_COLOR, CH_BLANK};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TEXT_COLOR  = 2'd0,
      REG_COLUMNS     = 2'd1,
      REG_LINES       = 2'd2,
      REG_SCREEN_ROWS = 2'd3
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic exec;
      logic scroll;
      logic blank;
      logic top;
      logic respond;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic is_eos;
      logic scroll_pos;
      logic scroll_neg;
      logic blank_last;
      logic rem_done;
   } dp_status_type;

endpackage

// ===== hw/rtl/tcce_remainder.sv =====
// Restoring remainder, one dividend bit per cycle.
module tcce_remainder #(
   parameter int DIV_W = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tcce_pkg::ROW_W-1:0] dividend,
   input  logic [DIV_W-1:0]           divisor,
   output logic                       done,
   output logic [DIV_W-1:0]           remainder
);

   localparam int CTW = $clog2(tcce_pkg::ROW_W + 1);

   logic                       running_ff;
   logic [CTW-1:0]             count_ff;
   logic [tcce_pkg::ROW_W-1:0] dvd_ff;
   logic [DIV_W-1:0]           rem_ff;
   logic [DIV_W:0]             trial;
   logic [DIV_W-1:0]           rem_in;

   always_comb begin
      trial = {rem_ff, dvd_ff[tcce_pkg::ROW_W-1]};
      if (trial >= {1'b0, divisor}) begin
         rem_in = DIV_W'(trial - {1'b0, divisor});
      end else begin
         rem_in = DIV_W'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         count_ff   <= '0;
      end else if (start) begin
         running_ff <= 1'b1;
         count_ff   <= CTW'(tcce_pkg::ROW_W);
      end else if (running_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == CTW'(1)) begin
            running_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
      end else if (running_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_in;
      end
   end

   assign done      = !running_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/tcce_ctrl.sv =====
// Sequencer: clear sweep, request execution, scroll, line blanking, response.
module tcce_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_strobe,
   output tcce_pkg::ctrl_cmd_type  cmd,
   input  tcce_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SCROLL,
      S_BLANK,
      S_TOP,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      strobe_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.is_read || !status.is_eos) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SCROLL;
            end
         end
         S_SCROLL: begin
            cmd.scroll = 1'b1;
            if (status.scroll_pos) begin
               state_in = S_BLANK;
            end else if (status.scroll_neg) begin
               state_in = S_TOP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_BLANK: begin
            cmd.blank = 1'b1;
            if (status.blank_last) begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            cmd.top = status.rem_done;
            if (status.rem_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.respond;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== hw/rtl/tcce_datapath.sv =====
// Registers, cursor arithmetic and the cell store.
module tcce_datapath #(
   parameter int MAX_COLUMNS = tcce_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_LINES   = tcce_pkg::MAX_LINES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tcce_pkg::ctrl_cmd_type                 cmd,
   output tcce_pkg::dp_status_type                status,
   input  logic                                   csr_write_enable,
   input  logic [tcce_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic                                   req_command,
   input  logic [tcce_pkg::CODE_W-1:0]            req_char_code,
   input  logic                                   req_end_of_string,
   input  logic [tcce_pkg::READ_LINE_W-1:0]       req_read_line,
   input  logic [tcce_pkg::READ_COL_W-1:0]        req_read_column,
   output logic [tcce_pkg::CELL_W-1:0]            rsp_cell_value,
   output logic [tcce_pkg::OUT_COL_W-1:0]         rsp_cursor_column,
   output logic [tcce_pkg::OUT_LINE_W-1:0]        rsp_cursor_buffer_line,
   output logic signed [tcce_pkg::ROW_W-1:0]      rsp_cursor_display_row,
   output logic [tcce_pkg::OUT_LINE_W-1:0]        rsp_scroll_top_line
);

   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int LW    = $clog2(MAX_LINES);
   localparam int CNW   = $clog2(MAX_COLUMNS + 1);
   localparam int LNW   = $clog2(MAX_LINES + 1);
   localparam int DEPTH = MAX_COLUMNS * MAX_LINES;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = tcce_pkg::ROW_W;

   function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] ln,
                                               input logic [CW-1:0] cl);
      return AW'(ln) * AW'(MAX_COLUMNS) + AW'(cl);
   endfunction

   // Configuration registers
   logic [tcce_pkg::COLOR_W-1:0]     color_ff;
   logic [tcce_pkg::CFG_COLS_W-1:0]  cols_cfg_ff;
   logic [tcce_pkg::CFG_LINES_W-1:0] lines_cfg_ff;
   logic [tcce_pkg::CFG_ROWS_W-1:0]  rows_cfg_ff;

   // Effective geometry
   logic [CNW-1:0] cols;
   logic [LNW-1:0] lines;
   logic [LNW-1:0] rows;

   // Latched request
   logic                               req_cmd_ff;
   logic [tcce_pkg::CODE_W-1:0]        req_code_ff;
   logic                               req_eos_ff;
   logic [tcce_pkg::READ_LINE_W-1:0]   req_line_ff;
   logic [tcce_pkg::READ_COL_W-1:0]    req_col_ff;

   // Cursor state
   logic [CW-1:0]        col_ff;
   logic [LW-1:0]        line_ff;
   logic signed [RW-1:0] row_ff;
   logic [LW-1:0]        top_ff;

   // Put step
   logic [CW-1:0]        col_c;
   logic [LW-1:0]        line_c;
   logic [LW-1:0]        top_c;
   logic [LW-1:0]        line_nx;
   logic [LW-1:0]        line_pv;
   logic signed [RW-1:0] row_inc;
   logic signed [RW-1:0] row_dec;
   logic [CW-1:0]        col_in;
   logic [LW-1:0]        line_in;
   logic signed [RW-1:0] row_in;
   logic                 put_we;
   logic [CW-1:0]        put_col;
   logic [LW-1:0]        put_line;
   logic [tcce_pkg::CODE_W-1:0] put_code;

   // Scroll and blanking
   logic signed [RW-1:0] rows_s;
   logic                 scroll_neg;
   logic                 scroll_pos;
   logic [RW-1:0]        mag_in;
   logic signed [RW-1:0] row_scroll_in;
   logic [LNW-1:0]       bcount_in;
   logic [LW-1:0]        bline_start;
   logic                 scroll_neg_ff;
   logic [CW-1:0]        bcol_ff;
   logic [LW-1:0]        bline_ff;
   logic [LNW-1:0]       bcount_ff;
   logic                 bcol_last;
   logic [LW-1:0]        bline_nx;

   // Top update
   logic [LNW-1:0] rem;
   logic           rem_done;
   logic [LNW:0]   top_sum;
   logic [LNW:0]   top_t;
   logic [LW-1:0]  top_in;

   // Store ports
   logic [AW-1:0]                clr_ff;
   logic                         we;
   logic [AW-1:0]                waddr;
   logic [tcce_pkg::CELL_W-1:0]  wdata;
   logic                         rd_in_range;
   logic [AW-1:0]                raddr;
   logic [tcce_pkg::CELL_W-1:0]  rdata_ff;
   logic [tcce_pkg::CELL_W-1:0]  mem [DEPTH];

   // Response registers
   logic [tcce_pkg::CELL_W-1:0]     rsp_cell_ff;
   logic [tcce_pkg::OUT_COL_W-1:0]  rsp_col_ff;
   logic [tcce_pkg::OUT_LINE_W-1:0] rsp_line_ff;
   logic signed [RW-1:0]            rsp_row_ff;
   logic [tcce_pkg::OUT_LINE_W-1:0] rsp_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= tcce_pkg::RST_TEXT_COLOR;
         cols_cfg_ff  <= tcce_pkg::RST_COLUMNS;
         lines_cfg_ff <= tcce_pkg::RST_LINES;
         rows_cfg_ff  <= tcce_pkg::RST_SCREEN_ROWS;
      end else if (csr_write_enable) begin
         case (tcce_pkg::csr_index_type'(csr_index))
            tcce_pkg::REG_TEXT_COLOR:  color_ff     <= csr_write_data;
            tcce_pkg::REG_COLUMNS:     cols_cfg_ff  <= csr_write_data;
            tcce_pkg::REG_LINES:       lines_cfg_ff <= csr_write_data[tcce_pkg::CFG_LINES_W-1:0];
            tcce_pkg::REG_SCREEN_ROWS: rows_cfg_ff  <= csr_write_data[tcce_pkg::CFG_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the registers into the usable geometry
   always_comb begin
      if (cols_cfg_ff == '0) begin
         cols = CNW'(1);
      end else if (32'(cols_cfg_ff) > MAX_COLUMNS) begin
         cols = CNW'(MAX_COLUMNS);
      end else begin
         cols = CNW'(cols_cfg_ff);
      end
      if (lines_cfg_ff == '0) begin
         lines = LNW'(1);
      end else if (32'(lines_cfg_ff) > MAX_LINES) begin
         lines = LNW'(MAX_LINES);
      end else begin
         lines = LNW'(lines_cfg_ff);
      end
      if (rows_cfg_ff == '0) begin
         rows = LNW'(1);
      end else if (32'(rows_cfg_ff) > 32'(lines)) begin
         rows = lines;
      end else begin
         rows = LNW'(rows_cfg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_cmd_ff  <= req_command;
         req_code_ff <= req_char_code;
         req_eos_ff  <= req_end_of_string;
         req_line_ff <= req_read_line;
         req_col_ff  <= req_read_column;
      end
   end

   // Character handling
   always_comb begin
      col_c   = (CNW'(col_ff) >= cols) ? CW'(cols - 1'b1) : col_ff;
      line_c  = (LNW'(line_ff) >= lines) ? LW'(lines - 1'b1) : line_ff;
      top_c   = (LNW'(top_ff) >= lines) ? LW'(lines - 1'b1) : top_ff;
      line_nx = (LNW'(line_c) + LNW'(1) == lines) ? '0 : LW'(line_c + 1'b1);
      line_pv = (line_c == '0) ? LW'(lines - 1'b1) : LW'(line_c - 1'b1);
      row_inc = (row_ff == tcce_pkg::ROW_MAX) ? row_ff : row_ff + 13'sd1;
      row_dec = (row_ff == tcce_pkg::ROW_MIN) ? row_ff : row_ff - 13'sd1;

      col_in   = col_c;
      line_in  = line_c;
      row_in   = row_ff;
      put_we   = 1'b0;
      put_col  = col_c;
      put_line = line_c;
      put_code = req_code_ff;

      case (req_code_ff)
         tcce_pkg::CH_NEWLINE: begin
            col_in  = '0;
            line_in = line_nx;
            row_in  = row_inc;
         end
         tcce_pkg::CH_BACKSPACE: begin
            if (col_c != '0) begin
               col_in = CW'(col_c - 1'b1);
            end else begin
               col_in  = CW'(cols - 1'b1);
               line_in = line_pv;
               row_in  = row_dec;
            end
            put_we   = 1'b1;
            put_col  = col_in;
            put_line = line_in;
            put_code = tcce_pkg::CH_BLANK;
         end
         tcce_pkg::CH_RETURN: begin
            col_in = '0;
         end
         default: begin
            put_we = 1'b1;
            if (CNW'(col_c) + CNW'(1) >= cols) begin
               col_in  = '0;
               line_in = line_nx;
               row_in  = row_inc;
            end else begin
               col_in = CW'(col_c + 1'b1);
            end
         end
      endcase
   end

   // Scroll amount from the display row
   always_comb begin
      rows_s     = RW'(rows);
      scroll_neg = (row_ff < 0);
      scroll_pos = !scroll_neg && (row_ff >= rows_s);
      if (scroll_neg) begin
         mag_in        = RW'(-row_ff);
         row_scroll_in = '0;
      end else if (scroll_pos) begin
         mag_in        = RW'(row_ff - rows_s + 13'sd1);
         row_scroll_in = rows_s - 13'sd1;
      end else begin
         mag_in        = '0;
         row_scroll_in = row_ff;
      end
      bcount_in   = (32'(mag_in) > 32'(lines)) ? lines : LNW'(mag_in);
      bline_start = (LNW'(line_ff) + LNW'(1) == lines) ? '0 : LW'(line_ff + 1'b1);
      bcol_last   = (CNW'(bcol_ff) + CNW'(1) == cols);
      bline_nx    = (LNW'(bline_ff) + LNW'(1) == lines) ? '0 : LW'(bline_ff + 1'b1);
   end

   tcce_remainder #(
      .DIV_W(LNW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.scroll),
      .dividend (mag_in),
      .divisor  (lines),
      .done     (rem_done),
      .remainder(rem)
   );

   // New ring top from the scroll remainder
   always_comb begin
      top_sum = (LNW+1)'(top_ff) + (LNW+1)'(rem);
      if (!scroll_neg_ff) begin
         top_t = (top_sum >= (LNW+1)'(lines)) ? top_sum - (LNW+1)'(lines) : top_sum;
      end else if (LNW'(top_ff) >= rem) begin
         top_t = (LNW+1)'(top_ff) - (LNW+1)'(rem);
      end else begin
         top_t = (LNW+1)'(top_ff) + (LNW+1)'(lines) - (LNW+1)'(rem);
      end
      top_in = LW'(top_t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
         row_ff  <= '0;
         top_ff  <= '0;
      end else begin
         if (cmd.exec && req_cmd_ff == tcce_pkg::CMD_PUT) begin
            col_ff  <= col_in;
            line_ff <= line_in;
            row_ff  <= row_in;
            top_ff  <= top_c;
         end
         if (cmd.scroll) begin
            row_ff <= row_scroll_in;
         end
         if (cmd.top) begin
            top_ff <= top_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scroll) begin
         scroll_neg_ff <= scroll_neg;
         bcol_ff       <= '0;
         bline_ff      <= bline_start;
         bcount_ff     <= bcount_in;
      end else if (cmd.blank) begin
         if (bcol_last) begin
            bcol_ff   <= '0;
            bline_ff  <= bline_nx;
            bcount_ff <= bcount_ff - 1'b1;
         end else begin
            bcol_ff <= bcol_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Single write port shared by clear sweep, put and blanking
   always_comb begin
      we    = 1'b0;
      waddr = '0;
      wdata = tcce_pkg::CELL_RESET;
      if (cmd.clear) begin
         we    = 1'b1;
         waddr = clr_ff;
      end else if (cmd.exec && req_cmd_ff == tcce_pkg::CMD_PUT) begin
         we    = put_we;
         waddr = cell_addr(put_line, put_col);
         wdata = {color_ff, put_code};
      end else if (cmd.blank) begin
         we    = 1'b1;
         waddr = cell_addr(bline_ff, bcol_ff);
         wdata = {color_ff, tcce_pkg::CH_BLANK};
      end
   end

   assign rd_in_range = (32'(req_line_ff) < MAX_LINES) && (32'(req_col_ff) < MAX_COLUMNS);
   assign raddr = rd_in_range ? cell_addr(LW'(req_line_ff), CW'(req_col_ff)) : '0;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_cell_ff <= (req_cmd_ff == tcce_pkg::CMD_READ && rd_in_range) ? rdata_ff : '0;
         rsp_col_ff  <= tcce_pkg::OUT_COL_W'(col_ff);
         rsp_line_ff <= tcce_pkg::OUT_LINE_W'(line_ff);
         rsp_row_ff  <= row_ff;
         rsp_top_ff  <= tcce_pkg::OUT_LINE_W'(top_ff);
      end
   end

   assign rsp_cell_value         = rsp_cell_ff;
   assign rsp_cursor_column      = rsp_col_ff;
   assign rsp_cursor_buffer_line = rsp_line_ff;
   assign rsp_cursor_display_row = rsp_row_ff;
   assign rsp_scroll_top_line    = rsp_top_ff;

   always_comb begin
      status            = '0;
      status.clear_last = (clr_ff == AW'(DEPTH - 1));
      status.is_read    = (req_cmd_ff == tcce_pkg::CMD_READ);
      status.is_eos     = req_eos_ff;
      status.scroll_pos = scroll_pos;
      status.scroll_neg = scroll_neg;
      status.blank_last = bcol_last && (bcount_ff == LNW'(1));
      status.rem_done   = rem_done;
   end

endmodule

// ===== hw/rtl/text_console_cursor_engine.sv =====
// Text console cursor engine over a ring of character lines.
// Request channel: a request is taken at a rising edge with start high and busy
// low. A put request (command 0) writes or interprets one string character; a
// read request (command 1) fetches one cell from the store.
// Result channel: rsp_strobe marks exactly one cycle in which the rsp_ ports
// carry the result; it cannot be held off, so capture it on that cycle.
// Configuration: csr_write_enable writes csr_write_data to register csr_index
// (text color, columns, lines, screen rows); write only while busy is low.
// Sequence: a read or a put without a string end passes latch, execute and
// respond; the next request can be taken in the cycle the strobe shows. A put
// with a string end adds a scroll decision. When it scrolls down, the line
// blanking runs one cell per cycle (lines blanked times columns) while the
// remainder unit wraps the ring top; a scroll up blanks no lines. The top
// update follows once the remainder is done.
// Reset: the store gets a clearing pass over all MAX_COLUMNS * MAX_LINES cells,
// one cell per cycle, with busy high; configuration writes are taken meanwhile.
module text_console_cursor_engine #(
   parameter int MAX_COLUMNS = tcce_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_LINES   = tcce_pkg::MAX_LINES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [tcce_pkg::CODE_W-1:0]         req_char_code,
   input  logic                                req_end_of_string,
   input  logic [tcce_pkg::READ_LINE_W-1:0]    req_read_line,
   input  logic [tcce_pkg::READ_COL_W-1:0]     req_read_column,
   // result channel
   output logic                                rsp_strobe,
   output logic [tcce_pkg::CELL_W-1:0]         rsp_cell_value,
   output logic [tcce_pkg::OUT_COL_W-1:0]      rsp_cursor_column,
   output logic [tcce_pkg::OUT_LINE_W-1:0]     rsp_cursor_buffer_line,
   output logic signed [tcce_pkg::ROW_W-1:0]   rsp_cursor_display_row,
   output logic [tcce_pkg::OUT_LINE_W-1:0]     rsp_scroll_top_line,
   // configuration port
   input  logic                                csr_write_enable,
   input  logic [tcce_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // Command and status between sequencer and datapath
   tcce_pkg::ctrl_cmd_type  cmd;
   tcce_pkg::dp_status_type status;

   // Sequencer: hold busy through clearing and every request, pulse the strobe
   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: registers, cursor math, scroll, cell store, response registers
   tcce_datapath #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_LINES  (MAX_LINES)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_command           (req_command),
      .req_char_code         (req_char_code),
      .req_end_of_string     (req_end_of_string),
      .req_read_line         (req_read_line),
      .req_read_column       (req_read_column),
      .rsp_cell_value        (rsp_cell_value),
      .rsp_cursor_column     (rsp_cursor_column),
      .rsp_cursor_buffer_line(rsp_cursor_buffer_line),
      .rsp_cursor_display_row(rsp_cursor_display_row),
      .rsp_scroll_top_line   (rsp_scroll_top_line)
   );

   // A taken request keeps the engine busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken but engine not busy");

   // One request gives one strobe: never two in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // A result follows work: the cycle before a strobe was busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a request in progress");

endmodule
